[src/tscc_pkg.sv]
// Shared types and constants for the timed stimulus and change capture block.
// Holds the request and result records, the event queue entry and the mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tscc_pkg;

  // Event queue geometry
  localparam int unsigned Q_DEPTH = 64;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = Q_AW + 1;

  // Request queue between front and back
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_CW    = FQ_AW + 1;

  // Stream widths
  localparam int unsigned IN_TDATA_W   = 80;
  localparam int unsigned IN_TUSER_W   = 2;
  localparam int unsigned OUT_FIELDS_W = 100;
  localparam int unsigned OUT_TDATA_W  = 104;

  // Mode codes on the request side
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_PUSH_DIG = 2'd1;
  localparam logic [1:0] MODE_PUSH_ANA = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_PUSH_DIG,
    KIND_PUSH_ANA,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] event_time;
    logic [15:0] event_value;
    logic [15:0] digital_in;
    logic [15:0] analog_in;
  } item_t;

  typedef struct packed {
    logic [31:0] when;
    logic [15:0] level;
  } evq_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } evq_stat_t;

  typedef struct packed {
    logic [15:0] port_out;
    logic [15:0] dac_out;
    logic        digital_changed;
    logic [15:0] digital_value;
    logic        analog_changed;
    logic [15:0] analog_value;
    logic [31:0] report_time;
    logic        finished;
    logic        push_rejected;
  } result_t;

endpackage
`default_nettype wire

[src/tscc_evq.sv]
// Timed event FIFO: entry memory, head and count, registered head read.
// Uses tscc_pkg. A push to a full queue and a pop of an empty one are ignored.
`timescale 1ns / 1ps
`default_nettype none
module tscc_evq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  tscc_pkg::evq_entry_t  push_entry,
  input  wire                   pop,
  output tscc_pkg::evq_entry_t  head_entry,
  output tscc_pkg::evq_stat_t   stat
);
  import tscc_pkg::*;

  evq_entry_t       mem [Q_DEPTH];
  logic [Q_AW-1:0]  head;
  logic [Q_CW-1:0]  count;
  logic [Q_AW:0]    tail_sum;
  logic [Q_AW-1:0]  tail;

  assign stat.full  = (count == Q_CW'(Q_DEPTH));
  assign stat.empty = (count == '0);

  // slot after the last entry, wrapped at the depth
  assign tail_sum = {1'b0, head} + count;
  assign tail     = (tail_sum >= Q_CW'(Q_DEPTH)) ? Q_AW'(tail_sum - Q_CW'(Q_DEPTH))
                                                 : tail_sum[Q_AW-1:0];

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem[tail] <= push_entry;
    end
    head_entry <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (push && !stat.full) begin
      count <= count + 1'b1;
    end else if (pop && !stat.empty) begin
      head  <= (head == Q_AW'(Q_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/tscc_front.sv]
// Request side: accepts stream requests, decodes the mode and queues them.
// Uses tscc_pkg. Feeds tscc_back through a small request queue.
`timescale 1ns / 1ps
`default_nettype none
module tscc_front (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [tscc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire  [tscc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                 item_valid,
  output tscc_pkg::item_t                      item,
  input  wire                                  item_pop
);
  import tscc_pkg::*;

  item_t             slot [FQ_DEPTH];
  item_t             decoded;
  logic [FQ_AW-1:0]  wr_ptr;
  logic [FQ_AW-1:0]  rd_ptr;
  logic [FQ_CW-1:0]  count;
  logic              accept;
  logic              take;

  always_comb begin
    case (s_axis_tuser)
      MODE_TICK:     decoded.kind = KIND_TICK;
      MODE_PUSH_DIG: decoded.kind = KIND_PUSH_DIG;
      MODE_PUSH_ANA: decoded.kind = KIND_PUSH_ANA;
      default:       decoded.kind = KIND_NONE;
    endcase
    decoded.event_time  = s_axis_tdata[31:0];
    decoded.event_value = s_axis_tdata[47:32];
    decoded.digital_in  = s_axis_tdata[63:48];
    decoded.analog_in   = s_axis_tdata[79:64];
  end

  assign s_axis_tready = (count != FQ_CW'(FQ_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (count != '0);
  assign take          = item_pop && item_valid;
  assign item          = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/tscc_back.sv]
// Execution side: tick counter, levels, change detection, both event queues.
// Uses tscc_pkg and tscc_evq. Holds the result register toward the output stream.
`timescale 1ns / 1ps
`default_nettype none
module tscc_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wen,
  input  wire  [31:0]          cfg_wdata,
  input  wire                  item_valid,
  input  tscc_pkg::item_t      item,
  output logic                 item_pop,
  output logic                 res_valid,
  input  wire                  res_ready,
  output tscc_pkg::result_t    res
);
  import tscc_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t       state;
  item_t        cur;
  logic [31:0]  capture_limit;
  logic [31:0]  tick_count;
  logic [15:0]  last_digital;
  logic [15:0]  last_analog;
  logic [15:0]  port_level;
  logic [15:0]  dac_level;

  evq_entry_t   dq_head, aq_head, push_entry;
  evq_stat_t    dq_stat, aq_stat;
  logic         commit, is_tick, fin, sampling;
  logic         d_fire, a_fire, d_push, a_push, rejected, d_chg, a_chg;

  assign push_entry = '{when: cur.event_time, level: cur.event_value};

  tscc_evq u_dq (
    .clk        (clk),
    .rst        (rst),
    .push       (d_push),
    .push_entry (push_entry),
    .pop        (d_fire),
    .head_entry (dq_head),
    .stat       (dq_stat)
  );

  tscc_evq u_aq (
    .clk        (clk),
    .rst        (rst),
    .push       (a_push),
    .push_entry (push_entry),
    .pop        (a_fire),
    .head_entry (aq_head),
    .stat       (aq_stat)
  );

  always_comb begin
    item_pop = (state == ST_IDLE) && item_valid;
    commit   = (state == ST_EXEC) && (!res_valid || res_ready);
    is_tick  = (cur.kind == KIND_TICK);
    fin      = (tick_count >= capture_limit);
    sampling = is_tick && !fin;
    // exact time match only: a missed head stays in front
    d_fire   = commit && is_tick && !dq_stat.empty && (dq_head.when == tick_count);
    a_fire   = commit && is_tick && !aq_stat.empty && (aq_head.when == tick_count);
    d_push   = commit && (cur.kind == KIND_PUSH_DIG);
    a_push   = commit && (cur.kind == KIND_PUSH_ANA);
    rejected = ((cur.kind == KIND_PUSH_DIG) && dq_stat.full) ||
               ((cur.kind == KIND_PUSH_ANA) && aq_stat.full);
    d_chg    = sampling && (cur.digital_in != last_digital);
    a_chg    = sampling && (cur.analog_in != last_analog);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      res_valid       <= 1'b0;
      capture_limit   <= '0;
      tick_count      <= '0;
      last_digital    <= '0;
      last_analog     <= '0;
      port_level      <= '0;
      dac_level       <= '0;
    end else begin
      if (cfg_wen) begin
        capture_limit <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (d_fire) port_level <= dq_head.level;
      if (a_fire) dac_level  <= aq_head.level;
      if (commit && sampling) begin
        tick_count <= tick_count + 1'b1;
        if (d_chg) last_digital <= cur.digital_in;
        if (a_chg) last_analog  <= cur.analog_in;
      end

      if (commit) begin
        res.port_out        <= d_fire ? dq_head.level : port_level;
        res.dac_out         <= a_fire ? aq_head.level : dac_level;
        res.digital_changed <= d_chg;
        res.digital_value   <= d_chg ? cur.digital_in : 16'd0;
        res.analog_changed  <= a_chg;
        res.analog_value    <= a_chg ? cur.analog_in : 16'd0;
        res.report_time     <= tick_count;
        res.finished        <= fin;
        res.push_rejected   <= rejected;
      end
    end
  end

endmodule
`default_nettype wire

[src/timed_stimulus_and_change_capture.sv]
// Timed stimulus and change capture, top level.
// Uses tscc_pkg, tscc_front, tscc_back (which holds two tscc_evq queues).
//
// Usage:
//   s_axis: one request per handshake. tuser carries the mode (tick, push a
//   digital event, push an analog event). A push stores (time, value) in the
//   matching 64-deep event queue; a full queue drops it and flags it.
//   A tick fires each queue head whose time equals the tick counter exactly,
//   then, while the counter is below capture_limit, reports input changes
//   with the counter value and advances the counter. A head whose time has
//   passed is never fired and blocks its queue.
//   m_axis: exactly one result per request, in request order.
//   cfg: cfg_wen writes capture_limit; write only while no request is open.
// Flow:
//   A request passes the front-end request queue, is loaded into the back end
//   in ST_IDLE with the registered head read of the event queue memories, then
//   compares, pops and commits its result in ST_EXEC; a stalled result holds
//   ST_EXEC. The back end takes no new request until the current one commits.
// Reset (rst, synchronous): counter, levels, last inputs and capture_limit
//   clear, both queues empty; no clearing pass is needed.
// Stall: a stalled m_axis keeps its result; the 2-entry request queue in the
//   front end keeps taking requests until it is full, then drops tready.
`timescale 1ns / 1ps
`default_nettype none
module timed_stimulus_and_change_capture (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_wen,
  input  wire  [31:0]                           cfg_wdata,   // capture_limit
  // request stream
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // event_time[31:0], event_value[47:32], digital_in[63:48], analog_in[79:64]
  input  wire  [tscc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // mode[1:0]
  input  wire  [tscc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // port_out[15:0], dac_out[31:16], digital_changed[32], digital_value[48:33],
  // analog_changed[49], analog_value[65:50], report_time[97:66],
  // finished[98], push_rejected[99], zero[103:100]
  output logic [tscc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import tscc_pkg::*;

  item_t    item;
  logic     item_valid;
  logic     item_pop;
  result_t  res;

  tscc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  tscc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // pack fields, first field in the low bits
  assign m_axis_tdata = {
    {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
    res.push_rejected,
    res.finished,
    res.report_time,
    res.analog_value,
    res.analog_changed,
    res.digital_value,
    res.digital_changed,
    res.dac_out,
    res.port_out
  };

  // once time is frozen no change can be reported
  a_fin_no_change: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.finished) |-> (!res.digital_changed && !res.analog_changed))
    else $error("change reported after sample duration");

  // a rejected push never reports an input change
  a_reject_no_change: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.push_rejected) |-> (!res.digital_changed && !res.analog_changed))
    else $error("rejected push carries a change report");

  // values are zero unless their change flag is set
  a_values_zeroed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.digital_changed || res.digital_value == 16'd0) &&
                       (res.analog_changed || res.analog_value == 16'd0)))
    else $error("report value without change flag");

endmodule
`default_nettype wire
